>>> src/mcpe_pkg.sv
// package for the multicolour cell palette encoder
// holds the item payload types, palette state type and fixed constants; no dependencies

package mcpe_pkg;

   // fixed geometry of a multicolour cell
   localparam int ROWS_PER_CELL = 8;
   localparam int PIXELS_PER_ROW = 4;
   localparam int PALETTE_SLOTS = 3;             // indices 1..3, index 0 is colour 0

   localparam logic [2:0] LAST_ROW = 3'(ROWS_PER_CELL - 1);
   localparam logic [1:0] SLOTS_FULL = 2'(PALETTE_SLOTS);

   typedef logic [3:0] colour_type;
   typedef logic [1:0] index_type;

   typedef struct packed {
      colour_type pixel_a;
      colour_type pixel_b;
      colour_type pixel_c;
      colour_type pixel_d;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] map_byte;
      logic [7:0] screen_byte;
      logic [3:0] colour_byte;
      logic       cell_done;
   } rsp_payload_type;

   // palette of the current cell: colours of indices 1..3 and how many are assigned
   typedef struct packed {
      colour_type [PALETTE_SLOTS-1:0] palette;
      logic [1:0]                     assigned;
   } palette_state_type;

endpackage

>>> src/mcpe_channels.sv
// valid/ready channel interfaces for the request and response items
// depends on mcpe_pkg for the payload types

interface mcpe_req_if;
   import mcpe_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface mcpe_rsp_if;
   import mcpe_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> src/mcpe_row_encode.sv
// combinational encoder for one cell row: four palette lookups, left to right
// depends on mcpe_pkg for the payload and palette state types

module mcpe_row_encode (
   input  mcpe_pkg::req_payload_type   pixels,
   input  mcpe_pkg::palette_state_type state_cur,
   output logic [7:0]                  map_byte,
   output mcpe_pkg::palette_state_type state_next
);
   import mcpe_pkg::*;

   colour_type [PIXELS_PER_ROW-1:0] pix;
   palette_state_type               st;
   logic [7:0]                      map;
   index_type                       idx;
   logic                            hit;

   // pix[0] is the leftmost pixel
   assign pix[0] = pixels.pixel_a;
   assign pix[1] = pixels.pixel_b;
   assign pix[2] = pixels.pixel_c;
   assign pix[3] = pixels.pixel_d;

   always_comb begin
      st  = state_cur;
      map = '0;
      idx = '0;
      hit = 1'b0;
      for (int p = 0; p < PIXELS_PER_ROW; p++) begin
         idx = '0;
         hit = 1'b0;
         if (pix[p] != '0) begin
            for (int k = 0; k < PALETTE_SLOTS; k++) begin
               if (!hit && (2'(k) < st.assigned) && (st.palette[k] == pix[p])) begin
                  idx = 2'(k + 1);
                  hit = 1'b1;
               end
            end
            // new colour takes the next free index while one is left
            if (!hit && (st.assigned != SLOTS_FULL)) begin
               for (int k = 0; k < PALETTE_SLOTS; k++) begin
                  if (2'(k) == st.assigned) begin
                     st.palette[k] = pix[p];
                  end
               end
               idx         = st.assigned + 2'd1;
               st.assigned = st.assigned + 2'd1;
            end
         end
         map[2*(PIXELS_PER_ROW-1-p) +: 2] = idx;
      end
   end

   assign map_byte   = map;
   assign state_next = st;

endmodule

>>> src/multicolor_cell_palette_encoder_unit.sv
// top level of the multicolour cell palette encoder
// depends on mcpe_pkg, the channel interfaces in mcpe_channels and mcpe_row_encode

// Takes one cell row of four double-wide pixel colours per item and returns one
// item per row: the map byte of four 2-bit palette indices (leftmost pixel in
// bits 7..6), and on the eighth row of a cell also the screen byte (colours of
// indices 1 and 2) and colour byte (colour of index 3) with cell_done set.
// Index 0 always stands for colour 0; new colours take indices 1, 2, 3 in order
// of first appearance, and once those are taken any further new colour maps to
// index 0. The palette and row count clear after the eighth row. The unit has
// an input register and a result register with the four lookups between them,
// so an accepted row passes through the input register and then the result
// register; a new row is accepted every cycle while the result is not stalled.
// The palette state register is updated by one row and read by the next. A
// stalled result holds the result register and a full input register; the
// input register takes an item only while it is empty.

module multicolor_cell_palette_encoder_unit (
   input logic        clock,
   input logic        reset,
   mcpe_req_if.sink   req,
   mcpe_rsp_if.source rsp
);
   import mcpe_pkg::*;

   // input stage
   logic              s1_valid_ff, s1_valid_in;
   req_payload_type   s1_pix_ff, s1_pix_in;

   // result stage
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_data_ff, rsp_data_in;

   // cell state
   palette_state_type pal_ff, pal_in;
   logic [2:0]        row_ff, row_in;

   // encoder outputs
   logic [7:0]        map_byte;
   palette_state_type pal_after;

   logic rsp_free;        // result register can take a new item this cycle
   logic s1_fire;         // input stage hands its row to the encoder
   logic req_fire;
   logic last_row;

   assign rsp_free  = !rsp_valid_ff || rsp.ready;
   assign s1_fire   = s1_valid_ff && rsp_free;
   assign req.ready = !s1_valid_ff || rsp_free;
   assign req_fire  = req.valid && req.ready;
   assign last_row  = (row_ff == LAST_ROW);

   mcpe_row_encode u_encode (
      .pixels     (s1_pix_ff),
      .state_cur  (pal_ff),
      .map_byte   (map_byte),
      .state_next (pal_after)
   );

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_pix_in    = s1_pix_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      pal_in       = pal_ff;
      row_in       = row_ff;

      if (req.ready) begin
         s1_valid_in = req.valid;
      end
      if (req_fire) begin
         s1_pix_in = req.payload;
      end
      if (rsp_free) begin
         rsp_valid_in = s1_valid_ff;
      end

      if (s1_fire) begin
         rsp_data_in.map_byte = map_byte;
         if (last_row) begin
            // cell complete: report the palette and start the next cell afresh
            rsp_data_in.screen_byte = {pal_after.palette[0], pal_after.palette[1]};
            rsp_data_in.colour_byte = pal_after.palette[2];
            rsp_data_in.cell_done   = 1'b1;
            pal_in                  = '0;
            row_in                  = '0;
         end else begin
            rsp_data_in.screen_byte = '0;
            rsp_data_in.colour_byte = '0;
            rsp_data_in.cell_done   = 1'b0;
            pal_in                  = pal_after;
            row_in                  = row_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pal_ff       <= '0;
         row_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pal_ff       <= pal_in;
         row_ff       <= row_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      s1_pix_ff   <= s1_pix_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

   // the eighth row always leaves a cleared palette and row count behind
   assert property (@(posedge clock) disable iff (reset)
      (s1_fire && last_row) |=> (pal_ff == '0) && (row_ff == '0))
      else $error("palette not cleared after cell end");

   // row count moves only when a row goes through the encoder
   assert property (@(posedge clock) disable iff (reset)
      !s1_fire |=> $stable(row_ff) && $stable(pal_ff))
      else $error("cell state changed without a row");

   // slots beyond the assigned count stay at colour 0
   assert property (@(posedge clock) disable iff (reset)
      ((pal_ff.assigned == 2'd0) |-> (pal_ff.palette == '0)) and
      ((pal_ff.assigned == 2'd1) |-> (pal_ff.palette[2:1] == '0)) and
      ((pal_ff.assigned == 2'd2) |-> (pal_ff.palette[2] == '0)))
      else $error("unassigned palette slot holds a colour");

   // screen and colour bytes are zero on rows that do not end a cell
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.cell_done) |->
         (rsp_data_ff.screen_byte == '0) && (rsp_data_ff.colour_byte == '0))
      else $error("cell bytes set before cell end");

endmodule
